// File: sv/bba_pkg.sv
package bba_pkg;

    localparam int POOL_ORDER = 8;
    localparam int POOL_UNITS = 1 << POOL_ORDER;
    localparam int IDX_W      = POOL_ORDER;
    localparam int CNT_W      = POOL_ORDER + 1;
    localparam int ADDR_W     = POOL_ORDER + 1;
    localparam int ORD_W      = 4;
    localparam int ENT_W      = 5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [8:0] req_size;
        logic [7:0] free_addr;
    } in_item_t;

    typedef struct packed {
        logic [7:0] alloc_addr;
        logic [1:0] status;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SPLIT,
        S_MARK,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_PULL_RD,
        S_PULL_WR,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load;
        logic scan_rd;
        logic scan_chk;
        logic shift_rd;
        logic shift_wr;
        logic split;
        logic mark;
        logic merge_rd;
        logic merge_chk;
        logic pull_rd;
        logic pull_wr;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic free_op;
        logic scan_end;
        logic scan_hit;
        logic scan_fail;
        logic need_split;
        logic shift_done;
        logic merge_go;
        logic merge_stop;
        logic pull_done;
        logic oversize;
    } stat_t;

endpackage

// File: sv/buddy_block_allocator.sv
// binary buddy allocator over 256 units
// in channel: in_valid/in_ready with in_item (op, req_size, free_addr)
// out channel: out_valid/out_ready with out_item (alloc_addr, status)
// one request is taken at a time; a result beat follows each request
// steps: the request is accepted, the list is scanned block by block,
// then each split or merge step moves list entries one by one, and the
// result beat follows
// the block list sits in one ram with a single write port; every list
// move is a read followed by a write to that ram, which sets the rate
// reset: the init state writes one free block of the whole pool into
// the list before the first beat is accepted
// stall: the result holds on out_item until out_ready; no new beat is
// taken until then
module buddy_block_allocator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bba_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output bba_pkg::out_item_t out_item
);

    bba_pkg::cmd_t  cmd;
    bba_pkg::stat_t stat;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bba_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_item  (in_item),
        .stat     (stat),
        .out_item (out_item)
    );

endmodule

// File: sv/bba_ram.sv
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/bba_ctrl.sv
module bba_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  bba_pkg::stat_t  stat,
    output bba_pkg::cmd_t   cmd
);

    bba_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bba_pkg::S_SCAN_RD;
                end
            end
            bba_pkg::S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                if (stat.oversize || stat.scan_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = bba_pkg::S_DONE;
                end
                else
                begin
                    state_next = bba_pkg::S_SCAN_CHK;
                end
            end
            bba_pkg::S_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
                if (stat.scan_fail)
                begin
                    state_next = bba_pkg::S_DONE;
                end
                else if (stat.scan_hit)
                begin
                    if (stat.free_op)
                    begin
                        state_next = bba_pkg::S_MERGE_RD;
                    end
                    else if (stat.need_split)
                    begin
                        state_next = bba_pkg::S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = bba_pkg::S_DONE;
                    end
                end
                else
                begin
                    state_next = bba_pkg::S_SCAN_RD;
                end
            end
            bba_pkg::S_SHIFT_RD:
            begin
                cmd.shift_rd = 1'b1;
                state_next   = stat.shift_done ? bba_pkg::S_SPLIT : bba_pkg::S_SHIFT_WR;
            end
            bba_pkg::S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = bba_pkg::S_SHIFT_RD;
            end
            bba_pkg::S_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = stat.need_split ? bba_pkg::S_SHIFT_RD : bba_pkg::S_MARK;
            end
            bba_pkg::S_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = bba_pkg::S_DONE;
            end
            bba_pkg::S_MERGE_RD:
            begin
                cmd.merge_rd = 1'b1;
                state_next   = stat.merge_stop ? bba_pkg::S_DONE : bba_pkg::S_MERGE_CHK;
            end
            bba_pkg::S_MERGE_CHK:
            begin
                cmd.merge_chk = 1'b1;
                state_next    = stat.merge_go ? bba_pkg::S_PULL_RD : bba_pkg::S_DONE;
            end
            bba_pkg::S_PULL_RD:
            begin
                cmd.pull_rd = 1'b1;
                state_next  = stat.pull_done ? bba_pkg::S_MERGE_RD : bba_pkg::S_PULL_WR;
            end
            bba_pkg::S_PULL_WR:
            begin
                cmd.pull_wr = 1'b1;
                state_next  = bba_pkg::S_PULL_RD;
            end
            bba_pkg::S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("in_ready and out_valid together");
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");
    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == bba_pkg::S_SCAN_RD))
        else $error("accepted item did not start a scan");

endmodule

// File: sv/bba_dp.sv
module bba_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  bba_pkg::cmd_t      cmd,
    input  bba_pkg::in_item_t  in_item,
    output bba_pkg::stat_t     stat,
    output bba_pkg::out_item_t out_item
);

    localparam int IW = bba_pkg::IDX_W;
    localparam int CW = bba_pkg::CNT_W;
    localparam int AW = bba_pkg::ADDR_W;
    localparam int OW = bba_pkg::ORD_W;

    // list entry: bit 4 used, bits 3..0 order
    logic                       we;
    logic [IW-1:0]              waddr, raddr;
    logic [bba_pkg::ENT_W-1:0]  wdata, rdata;

    bba_ram #(.WIDTH(bba_pkg::ENT_W), .DEPTH(bba_pkg::POOL_UNITS)) u_list (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;    // current block index
    logic [CW-1:0] ptr_reg, ptr_next;    // shift pointer
    logic [AW-1:0] addr_reg, addr_next;  // start address of current block
    logic [OW-1:0] need_reg, need_next;
    logic [OW-1:0] ord_reg, ord_next;    // order of current block
    logic [bba_pkg::ENT_W-1:0] cur_reg, cur_next;
    logic          left_reg, left_next;  // buddy lies left
    logic [1:0]    status_reg, status_next;
    logic [7:0]    aout_reg, aout_next;
    logic          op_reg;
    logic [7:0]    target_reg;

    logic [OW-1:0] need_calc;
    logic [9:0]    sz_m1;
    logic [AW:0]   addr_sum;
    logic [AW-1:0] bsize;

    // ceil log2 of the request
    always_comb
    begin
        sz_m1     = (in_item.req_size == 9'd0) ? 10'd0 : {1'b0, in_item.req_size} - 10'd1;
        need_calc = '0;
        for (int b = 0; b < 10; b++)
        begin
            if (sz_m1[b])
            begin
                need_calc = OW'(b + 1);
            end
        end
    end

    assign bsize    = AW'(1) << ord_reg;
    assign addr_sum = {1'b0, addr_reg} + {1'b0, (AW'(1) << rdata[OW-1:0])};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CW'(1);
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        ptr_reg    <= ptr_next;
        addr_reg   <= addr_next;
        need_reg   <= need_next;
        ord_reg    <= ord_next;
        cur_reg    <= cur_next;
        left_reg   <= left_next;
        status_reg <= status_next;
        aout_reg   <= aout_next;
        if (cmd.load)
        begin
            op_reg     <= in_item.op;
            target_reg <= in_item.free_addr;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        ptr_next    = ptr_reg;
        addr_next   = addr_reg;
        need_next   = need_reg;
        ord_next    = ord_reg;
        cur_next    = cur_reg;
        left_next   = left_reg;
        status_next = status_reg;
        aout_next   = aout_reg;
        we          = 1'b0;
        waddr       = idx_reg[IW-1:0];
        wdata       = '0;
        raddr       = idx_reg[IW-1:0];
        stat        = '0;

        stat.free_op    = (op_reg == bba_pkg::OP_FREE);
        stat.oversize   = (op_reg == bba_pkg::OP_ALLOC) &&
                          (need_reg > OW'(bba_pkg::POOL_ORDER));
        stat.scan_end   = (idx_reg >= count_reg);
        stat.need_split = (ord_reg > need_reg);
        stat.shift_done = (ptr_reg == idx_reg);
        stat.pull_done  = (ptr_reg >= count_reg);

        if (cmd.clear_step)
        begin
            we       = 1'b1;
            waddr    = '0;
            wdata    = {1'b0, OW'(bba_pkg::POOL_ORDER)};
            stat.clear_done = 1'b1;
        end

        if (cmd.load)
        begin
            idx_next    = '0;
            addr_next   = '0;
            need_next   = need_calc;
            status_next = (in_item.op == bba_pkg::OP_ALLOC) ? bba_pkg::ST_NO_FIT
                                                            : bba_pkg::ST_NOT_FOUND;
            aout_next   = '0;
        end

        if (cmd.scan_rd)
        begin
            raddr = idx_reg[IW-1:0];
        end

        if (cmd.scan_chk)
        begin
            ord_next = rdata[OW-1:0];
            cur_next = rdata;
            if (op_reg == bba_pkg::OP_ALLOC)
            begin
                if (!rdata[OW] && rdata[OW-1:0] >= need_reg)
                begin
                    stat.scan_hit = 1'b1;
                    stat.need_split = rdata[OW-1:0] > need_reg;
                    ptr_next    = count_reg;
                    status_next = bba_pkg::ST_OK;
                    aout_next   = addr_reg[7:0];
                    if (rdata[OW-1:0] == need_reg)
                    begin
                        we    = 1'b1;
                        wdata = {1'b1, rdata[OW-1:0]};
                    end
                end
                else
                begin
                    addr_next = addr_sum[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                end
            end
            else
            begin
                if (addr_reg == AW'(target_reg))
                begin
                    if (!rdata[OW])
                    begin
                        stat.scan_fail = 1'b1;
                    end
                    else
                    begin
                        stat.scan_hit = 1'b1;
                        status_next   = bba_pkg::ST_OK;
                        we    = 1'b1;
                        wdata = {1'b0, rdata[OW-1:0]};
                        cur_next = {1'b0, rdata[OW-1:0]};
                    end
                end
                else if (addr_reg > AW'(target_reg))
                begin
                    stat.scan_fail = 1'b1;
                end
                else
                begin
                    addr_next = addr_sum[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                end
            end
        end

        // open a slot at idx+1 by moving entries up, top first
        if (cmd.shift_rd)
        begin
            raddr = IW'(ptr_reg - CW'(1));
        end
        if (cmd.shift_wr)
        begin
            we       = 1'b1;
            waddr    = ptr_reg[IW-1:0];
            wdata    = rdata;
            ptr_next = ptr_reg - CW'(1);
        end
        // upper half goes to idx+1; the lower half at idx is written once it fits
        if (cmd.split)
        begin
            we         = 1'b1;
            waddr      = IW'(idx_reg + CW'(1));
            wdata      = {1'b0, ord_reg - OW'(1)};
            ord_next   = ord_reg - OW'(1);
            count_next = count_reg + CW'(1);
            ptr_next   = count_reg + CW'(1);
            stat.need_split = (ord_reg - OW'(1)) > need_reg;
        end
        if (cmd.mark)
        begin
            we    = 1'b1;
            wdata = {1'b1, ord_reg};
        end

        // merge: look at the buddy entry
        if (cmd.merge_rd)
        begin
            left_next = (addr_reg & ((bsize << 1) - AW'(1))) != '0;
            if (ord_reg >= OW'(bba_pkg::POOL_ORDER))
            begin
                stat.merge_stop = 1'b1;
            end
            else if ((addr_reg & ((bsize << 1) - AW'(1))) != '0)
            begin
                stat.merge_stop = (idx_reg == '0);
                raddr = IW'(idx_reg - CW'(1));
            end
            else
            begin
                stat.merge_stop = (idx_reg + CW'(1) >= count_reg);
                raddr = IW'(idx_reg + CW'(1));
            end
        end
        if (cmd.merge_chk)
        begin
            if (rdata == cur_reg)
            begin
                stat.merge_go = 1'b1;
                if (left_reg)
                begin
                    idx_next  = idx_reg - CW'(1);
                    addr_next = addr_reg - bsize;
                    waddr     = IW'(idx_reg - CW'(1));
                    ptr_next  = idx_reg + CW'(1);
                end
                else
                begin
                    ptr_next  = idx_reg + CW'(2);
                end
                we       = 1'b1;
                wdata    = {1'b0, ord_reg + OW'(1)};
                cur_next = {1'b0, ord_reg + OW'(1)};
                ord_next = ord_reg + OW'(1);
                count_next = count_reg - CW'(1);
            end
        end
        // close the gap: entry ptr moves down to ptr-1
        if (cmd.pull_rd)
        begin
            raddr = ptr_reg[IW-1:0];
            stat.pull_done = (ptr_reg >= count_reg + CW'(1));
        end
        if (cmd.pull_wr)
        begin
            we       = 1'b1;
            waddr    = IW'(ptr_reg - CW'(1));
            wdata    = rdata;
            ptr_next = ptr_reg + CW'(1);
        end
    end

    bba_pkg::out_item_t res;
    always_comb
    begin
        res.alloc_addr = aout_reg;
        res.status     = status_reg;
    end
    assign out_item = res;

    a_count_pos: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0)
        else $error("block count reached zero");
    a_split_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.split |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("split did not grow the list");
    a_merge_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.merge_chk && stat.merge_go) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("merge did not shrink the list");

endmodule
